@@ src/cbrf_pkg.sv @@
// Shared types and constants of the cubic bisection root finder.
// Depends on nothing; every other source file imports it.
package cbrf_pkg;

  localparam int unsigned CoefWidth = 16;
  localparam int unsigned XWidth    = 32;
  localparam int unsigned AccWidth  = 48;
  localparam int unsigned OpAWidth  = 25;
  localparam int unsigned ProdWidth = OpAWidth + XWidth;
  localparam int unsigned TolWidth  = 31;
  localparam int unsigned StepWidth = 6;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam int unsigned MaxIterDefault = 48;

  // Register indexes on the configuration port (byte address is 4 * index)
  localparam logic [2:0] RegCubic  = 3'd0;
  localparam logic [2:0] RegSquare = 3'd1;
  localparam logic [2:0] RegLinear = 3'd2;
  localparam logic [2:0] RegConst  = 3'd3;
  localparam logic [2:0] RegTol    = 3'd4;

  // Reset values: -2.75, 18, -21, -12 in Q8.8 and about 1e-5 in Q8.24
  localparam logic [CoefWidth-1:0] CubicReset  = 16'hFD40;
  localparam logic [CoefWidth-1:0] SquareReset = 16'h1200;
  localparam logic [CoefWidth-1:0] LinearReset = 16'hEB00;
  localparam logic [CoefWidth-1:0] ConstReset  = 16'hF400;
  localparam logic [TolWidth-1:0]  TolReset    = 31'd168;

  typedef struct packed {
    logic signed [CoefWidth-1:0] cubic;
    logic signed [CoefWidth-1:0] square;
    logic signed [CoefWidth-1:0] linear;
    logic signed [CoefWidth-1:0] konst;
  } coef_t;

  typedef struct packed {
    logic                     start;
    logic signed [XWidth-1:0] x;
  } poly_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [AccWidth-1:0] value;
  } poly_rsp_t;

endpackage

@@ src/cbrf_regs.sv @@
// Configuration registers of the root finder behind an APB-style port.
// Depends on cbrf_pkg for register indexes, reset values and coef_t.
module cbrf_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbrf_pkg::AddrWidth-1:0]    paddr,
  input  logic [cbrf_pkg::DataWidth-1:0]    pwdata,
  output logic [cbrf_pkg::DataWidth-1:0]    prdata,
  output logic                              pready,
  output cbrf_pkg::coef_t                   coef_o,
  output logic [cbrf_pkg::TolWidth-1:0]     tol_o
);
  import cbrf_pkg::*;

  coef_t               coef_q;
  logic [TolWidth-1:0] tol_q;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.cubic  <= CubicReset;
      coef_q.square <= SquareReset;
      coef_q.linear <= LinearReset;
      coef_q.konst  <= ConstReset;
      tol_q         <= TolReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegCubic:  coef_q.cubic  <= pwdata[CoefWidth-1:0];
        RegSquare: coef_q.square <= pwdata[CoefWidth-1:0];
        RegLinear: coef_q.linear <= pwdata[CoefWidth-1:0];
        RegConst:  coef_q.konst  <= pwdata[CoefWidth-1:0];
        RegTol:    tol_q         <= pwdata[TolWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegCubic:  prdata = {{(DataWidth-CoefWidth){1'b0}}, coef_q.cubic};
      RegSquare: prdata = {{(DataWidth-CoefWidth){1'b0}}, coef_q.square};
      RegLinear: prdata = {{(DataWidth-CoefWidth){1'b0}}, coef_q.linear};
      RegConst:  prdata = {{(DataWidth-CoefWidth){1'b0}}, coef_q.konst};
      RegTol:    prdata = {{(DataWidth-TolWidth){1'b0}}, tol_q};
      default:   prdata = '0;
    endcase
  end

  assign coef_o = coef_q;
  assign tol_o  = tol_q;

endmodule

@@ src/cbrf_mul.sv @@
// Shared signed 25 x 32 multiplier with a registered product.
// Depends on cbrf_pkg for operand and product widths.
module cbrf_mul (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [cbrf_pkg::OpAWidth-1:0]  a_i,
  input  logic signed [cbrf_pkg::XWidth-1:0]    b_i,
  output logic signed [cbrf_pkg::ProdWidth-1:0] prod_o
);
  import cbrf_pkg::*;

  logic signed [ProdWidth-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ src/cbrf_horner.sv @@
// Horner evaluation of the cubic in Q24.24 with saturation, using cbrf_mul.
// Each stage splits the 48-bit accumulator into low and high halves.
// Depends on cbrf_pkg and cbrf_mul.
module cbrf_horner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbrf_pkg::coef_t     coef_i,
  input  cbrf_pkg::poly_req_t req_i,
  output cbrf_pkg::poly_rsp_t rsp_o
);
  import cbrf_pkg::*;

  typedef enum logic [1:0] {HIdle, HLo, HHi, HAdd} state_e;

  localparam int unsigned PartWidth = ProdWidth - 24 + 1;
  localparam int unsigned SumWidth  = ProdWidth + 1;

  state_e                      state_q;
  logic [1:0]                  stage_q;
  logic signed [XWidth-1:0]    x_q;
  logic signed [AccWidth-1:0]  acc_q;
  logic signed [PartWidth-1:0] part_q;
  logic                        done_q;

  logic signed [OpAWidth-1:0]  mul_a;
  logic                        mul_en;
  logic signed [ProdWidth-1:0] prod;
  logic signed [CoefWidth-1:0] coef_sel;
  logic signed [PartWidth-1:0] part_d;
  logic signed [SumWidth-1:0]  sum;
  logic signed [AccWidth-1:0]  sat;

  // low half as an unsigned operand, high half as the signed one
  assign mul_a  = (state_q == HHi) ? {acc_q[AccWidth-1], acc_q[AccWidth-1:24]}
                                   : {1'b0, acc_q[23:0]};
  assign mul_en = (state_q == HLo) || (state_q == HHi);

  cbrf_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (x_q),
    .prod_o (prod)
  );

  always_comb begin
    case (stage_q)
      2'd0:    coef_sel = coef_i.square;
      2'd1:    coef_sel = coef_i.linear;
      default: coef_sel = coef_i.konst;
    endcase
    // floor of the low product over 2^24, plus the next coefficient in Q24.24
    part_d = {prod[ProdWidth-1], prod[ProdWidth-1:24]}
           + {{(PartWidth-CoefWidth-16){coef_sel[CoefWidth-1]}}, coef_sel, 16'b0};
    sum = {prod[ProdWidth-1], prod}
        + {{(SumWidth-PartWidth){part_q[PartWidth-1]}}, part_q};
    if (sum[SumWidth-1:AccWidth-1] == {(SumWidth-AccWidth+1){sum[SumWidth-1]}}) begin
      sat = sum[AccWidth-1:0];
    end else if (sum[SumWidth-1]) begin
      sat = {1'b1, {(AccWidth-1){1'b0}}};
    end else begin
      sat = {1'b0, {(AccWidth-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
      stage_q <= '0;
      x_q     <= '0;
      acc_q   <= '0;
      part_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        HIdle: begin
          done_q <= 1'b0;
          if (req_i.start) begin
            x_q     <= req_i.x;
            acc_q   <= {{(AccWidth-CoefWidth-16){coef_i.cubic[CoefWidth-1]}},
                        coef_i.cubic, 16'b0};
            stage_q <= '0;
            state_q <= HLo;
          end
        end
        HLo: begin
          done_q  <= 1'b0;
          state_q <= HHi;
        end
        HHi: begin
          done_q  <= 1'b0;
          part_q  <= part_d;
          state_q <= HAdd;
        end
        HAdd: begin
          acc_q  <= sat;
          done_q <= (stage_q == 2'd2);
          if (stage_q == 2'd2) begin
            state_q <= HIdle;
          end else begin
            stage_q <= stage_q + 2'd1;
            state_q <= HLo;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= HIdle;
        end
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

endmodule

@@ src/cubic_bisection_root_finder_core.sv @@
// Top level of the cubic bisection root finder: step sequencer and result beat.
// Depends on cbrf_pkg, cbrf_regs, cbrf_horner (which holds cbrf_mul).
//
//   port group   direction  beat taken when             payload
//   in           in         in_valid_i & !in_stall_o    lower_end_i, upper_end_i
//   out          out        out_valid_o & !out_stall_i  root_o, steps_taken_o, hit_limit_o
//   apb          in/out     psel & penable & pwrite     paddr, pwdata, prdata
//
// One interval takes up to MaxIter steps; each step is one cubic evaluation on the shared
// multiplier plus sequencing.
// f(a) is kept across steps, so each step evaluates only the midpoint.
// Reset is asynchronous and active low; registers return to their listed values.
// in_stall_o is high while an interval is in work; a finished result waits
// in the output register while a new interval may be taken.
module cubic_bisection_root_finder_core #(
  parameter int unsigned MaxIter = cbrf_pkg::MaxIterDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cbrf_pkg::XWidth-1:0]  lower_end_i,
  input  logic signed [cbrf_pkg::XWidth-1:0]  upper_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cbrf_pkg::XWidth-1:0]  root_o,
  output logic [cbrf_pkg::StepWidth-1:0]      steps_taken_o,
  output logic                                hit_limit_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbrf_pkg::AddrWidth-1:0]      paddr,
  input  logic [cbrf_pkg::DataWidth-1:0]      pwdata,
  output logic [cbrf_pkg::DataWidth-1:0]      prdata,
  output logic                                pready
);
  import cbrf_pkg::*;

  typedef enum logic [2:0] {SIdle, SEvalA, SCheck, SEvalM, SEvalB, SOut} state_e;

  localparam logic [StepWidth-1:0] StepLimit = StepWidth'(MaxIter);

  coef_t               coef;
  logic [TolWidth-1:0] tol;
  poly_req_t           req_q;
  poly_rsp_t           rsp;

  state_e                     state_q;
  logic signed [XWidth-1:0]   a_q;
  logic signed [XWidth-1:0]   b_q;
  logic signed [XWidth-1:0]   mid_q;
  logic signed [XWidth-1:0]   sel_q;
  logic signed [AccWidth-1:0] fa_q;
  logic [StepWidth-1:0]       step_q;
  logic                       limit_q;
  logic                       out_valid_q;
  logic signed [XWidth-1:0]   root_q;
  logic [StepWidth-1:0]       steps_q;
  logic                       hit_q;

  logic signed [XWidth:0] diff;
  logic [XWidth:0]        span;
  logic signed [XWidth:0] sum_ab;
  logic                   wide;
  logic                   more;
  logic                   opposite;
  logic                   out_free;

  cbrf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef),
    .tol_o   (tol)
  );

  cbrf_horner u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  always_comb begin
    diff     = {a_q[XWidth-1], a_q} - {b_q[XWidth-1], b_q};
    span     = diff[XWidth] ? -diff : diff;
    wide     = span > {2'b00, tol};
    more     = wide && (step_q < StepLimit);
    sum_ab   = {a_q[XWidth-1], a_q} + {b_q[XWidth-1], b_q};
    // strict opposite signs of f(a) and f(mid); zero counts as neither
    opposite = (!fa_q[AccWidth-1] && (fa_q != '0) && rsp.value[AccWidth-1])
            || (fa_q[AccWidth-1] && !rsp.value[AccWidth-1] && (rsp.value != '0));
    out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      req_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      mid_q       <= '0;
      sel_q       <= '0;
      fa_q        <= '0;
      step_q      <= '0;
      limit_q     <= 1'b0;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      steps_q     <= '0;
      hit_q       <= 1'b0;
    end else begin
      // drop the result beat once taken, unless a new one is loaded now
      if (out_valid_q && !out_stall_i && (state_q != SOut)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          req_q.start <= in_valid_i;
          if (in_valid_i) begin
            a_q         <= lower_end_i;
            b_q         <= upper_end_i;
            step_q      <= '0;
            req_q.x     <= lower_end_i;
            state_q     <= SEvalA;
          end
        end
        SEvalA: begin
          req_q.start <= 1'b0;
          if (rsp.done) begin
            fa_q    <= rsp.value;
            state_q <= SCheck;
          end
        end
        SCheck: begin
          req_q.start <= 1'b1;
          if (more) begin
            mid_q   <= sum_ab[XWidth:1];
            req_q.x <= sum_ab[XWidth:1];
            state_q <= SEvalM;
          end else begin
            limit_q <= wide;
            req_q.x <= b_q;
            state_q <= SEvalB;
          end
        end
        SEvalM: begin
          req_q.start <= 1'b0;
          if (rsp.done) begin
            if (opposite) begin
              b_q <= mid_q;
            end else begin
              a_q  <= mid_q;
              fa_q <= rsp.value;
            end
            step_q  <= step_q + 1'b1;
            state_q <= SCheck;
          end
        end
        SEvalB: begin
          req_q.start <= 1'b0;
          if (rsp.done) begin
            sel_q   <= (fa_q < rsp.value) ? a_q : b_q;
            state_q <= SOut;
          end
        end
        SOut: begin
          req_q.start <= 1'b0;
          // hold until the previous result beat has left
          if (out_free) begin
            root_q      <= sel_q;
            steps_q     <= step_q;
            hit_q       <= limit_q;
            out_valid_q <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: begin
          req_q.start <= 1'b0;
          state_q     <= SIdle;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != SIdle);
  assign out_valid_o   = out_valid_q;
  assign root_o        = root_q;
  assign steps_taken_o = steps_q;
  assign hit_limit_o   = hit_q;

endmodule

@@ sim/cubic_bisection_root_finder_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for cubic_bisection_root_finder_core: random and edge-case intervals
// against a bit-exact bisection predictor. Depends on cbrf_pkg and the core RTL only.
module cubic_bisection_root_finder_core_tb;
  import cbrf_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned LimitCycles   = 6_000_000;
  localparam int unsigned SettleCycles  = 32;
  localparam int unsigned EndSettle     = 700;
  localparam int unsigned HoldCycles    = 2500;
  localparam int unsigned MaxGap        = 40;
  localparam int unsigned PhaseItems    = 450;
  localparam int unsigned PressureItems = 24;
  localparam int unsigned ReportLimit   = 10;

  localparam logic [2:0] RegSpareLo = RegTol + 3'd1;
  localparam logic [2:0] RegSpareHi = 3'd7;

  localparam logic signed [XWidth-1:0] XMin = 32'sh8000_0000;
  localparam logic signed [XWidth-1:0] XMax = 32'sh7FFF_FFFF;
  localparam logic signed [XWidth-1:0] XOne = 32'sh0100_0000;

  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;

  typedef struct packed {
    logic signed [XWidth-1:0] root;
    logic [StepWidth-1:0]     steps;
    logic                     hit_limit;
  } root_beat_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [XWidth-1:0]    lower_end_i;
  logic signed [XWidth-1:0]    upper_end_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [XWidth-1:0]    root_o;
  logic [StepWidth-1:0]        steps_taken_o;
  logic                        hit_limit_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [AddrWidth-1:0]        paddr;
  logic [DataWidth-1:0]        pwdata;
  logic [DataWidth-1:0]        prdata;
  logic                        pready;

  // predictor copy of the register file
  coef_t                coefs;
  logic [TolWidth-1:0]  tol_q24;

  root_beat_t  pending_roots[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_active;
  event        hold_off_ev;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned intervals_sent;
  int unsigned roots_checked;
  int unsigned limit_hits;
  int unsigned zero_step_roots;
  int unsigned reg_writes;

  cubic_bisection_root_finder_core #(
    .MaxIter(MaxIterDefault)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .lower_end_i  (lower_end_i),
    .upper_end_i  (upper_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .root_o       (root_o),
    .steps_taken_o(steps_taken_o),
    .hit_limit_o  (hit_limit_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_roots.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_acc(input longint v);
    if (v > AccMax) return AccMax;
    if (v < AccMin) return AccMin;
    return v;
  endfunction

  // floor(acc * x / 2^24) split in whole and fraction so nothing overflows
  function automatic longint scale_q24(input longint acc, input longint x);
    longint whole;
    longint frac;
    whole = acc >>> 24;
    frac  = acc - (whole <<< 24);
    return whole * x + ((frac * x) >>> 24);
  endfunction

  function automatic longint eval_cubic(input longint x);
    longint acc;
    acc = longint'(coefs.cubic) * 65536;
    acc = clamp_acc(scale_q24(acc, x) + longint'(coefs.square) * 65536);
    acc = clamp_acc(scale_q24(acc, x) + longint'(coefs.linear) * 65536);
    acc = clamp_acc(scale_q24(acc, x) + longint'(coefs.konst) * 65536);
    return acc;
  endfunction

  function automatic longint width_between(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic root_beat_t predict_root(input logic signed [XWidth-1:0] lo_end,
                                              input logic signed [XWidth-1:0] hi_end);
    longint      a;
    longint      b;
    longint      mid;
    longint      fa;
    longint      fm;
    int unsigned steps;
    root_beat_t  beat;
    a = lo_end;
    b = hi_end;
    steps = 0;
    while (width_between(a, b) > longint'(tol_q24) && steps < MaxIterDefault) begin
      mid = (a + b) >>> 1;
      fa  = eval_cubic(a);
      fm  = eval_cubic(mid);
      // keep [a, mid] if its ends differ strictly in sign, else keep [mid, b]
      if ((fa > 0 && fm < 0) || (fa < 0 && fm > 0)) b = mid;
      else a = mid;
      steps++;
    end
    beat.hit_limit = width_between(a, b) > longint'(tol_q24);
    beat.steps     = StepWidth'(steps);
    beat.root      = (eval_cubic(a) < eval_cubic(b)) ? XWidth'(a) : XWidth'(b);
    return beat;
  endfunction

  // ---------------------------------------------------------------- receiver side

  always @(posedge clk_i) begin
    if (hold_active) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off, counted here so the sender keeps going meanwhile
  always begin
    @(hold_off_ev);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  task automatic check_root_beat();
    root_beat_t want;
    if (pending_roots.size() == 0) begin
      if (mismatch_count < ReportLimit) begin
        $display("cycle %0d: result beat with nothing pending: root %h steps %0d limit %0b",
                 cycle_count, root_o, steps_taken_o, hit_limit_o);
      end
      mismatch_count++;
      return;
    end
    want = pending_roots.pop_front();
    roots_checked++;
    if (want.hit_limit) limit_hits++;
    if (want.steps == '0) zero_step_roots++;
    if (root_o !== want.root || steps_taken_o !== want.steps ||
        hit_limit_o !== want.hit_limit) begin
      if (mismatch_count < ReportLimit) begin
        $display("cycle %0d: mismatch on result %0d (expected/actual)", cycle_count,
                 roots_checked);
        $display("  root %h/%h  steps %0d/%0d  hit_limit %0b/%0b", want.root, root_o,
                 want.steps, steps_taken_o, want.hit_limit, hit_limit_o);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_root_beat();
  end

  // ---------------------------------------------------------------- sender side

  task automatic send_interval(input logic signed [XWidth-1:0] lo_end,
                               input logic signed [XWidth-1:0] hi_end);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    lower_end_i <= lo_end;
    upper_end_i <= hi_end;
    do @(posedge clk_i); while (in_stall_o);
    pending_roots.push_back(predict_root(lo_end, hi_end));
    intervals_sent++;
  endtask

  // drop valid, wait for every pending result, then let the core settle
  task automatic drain_results(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic drive_reg(input logic [2:0] idx, input logic [DataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegCubic:  coefs.cubic  = data[CoefWidth-1:0];
      RegSquare: coefs.square = data[CoefWidth-1:0];
      RegLinear: coefs.linear = data[CoefWidth-1:0];
      RegConst:  coefs.konst  = data[CoefWidth-1:0];
      RegTol:    tol_q24      = data[TolWidth-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [DataWidth-1:0] coef_word(input logic [CoefWidth-1:0] v);
    return {{(DataWidth - CoefWidth){v[CoefWidth-1]}}, v};
  endfunction

  task automatic program_random_config();
    logic [TolWidth-1:0] tol_pick;
    drive_reg(RegCubic,  coef_word($urandom_range(1) ? CubicReset  : 16'($urandom)));
    drive_reg(RegSquare, coef_word($urandom_range(1) ? SquareReset : 16'($urandom)));
    drive_reg(RegLinear, coef_word($urandom_range(1) ? LinearReset : 16'($urandom)));
    drive_reg(RegConst,  coef_word($urandom_range(1) ? ConstReset  : 16'($urandom)));
    // keep step counts moderate so the run stays short
    tol_pick = (31'd1 << $urandom_range(26, 8)) | 31'($urandom_range(255));
    drive_reg(RegTol, {1'b0, tol_pick});
  endtask

  function automatic void pick_endpoints(output logic signed [XWidth-1:0] lo_end,
                                         output logic signed [XWidth-1:0] hi_end);
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 50) begin
      lo_end = $urandom;
      hi_end = $urandom;
    end else if (mode < 75) begin
      // within +-8.0, where the interesting roots lie
      lo_end = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
      hi_end = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
    end else if (mode < 90) begin
      lo_end = $urandom;
      hi_end = lo_end + (int'($urandom_range(4096)) - 2048);
    end else begin
      case ($urandom_range(3))
        0: lo_end = XMin;
        1: lo_end = XMax;
        2: lo_end = '0;
        default: lo_end = '1;
      endcase
      hi_end = $urandom_range(1) ? XMin : XMax;
      if ($urandom_range(1)) hi_end = $urandom;
    end
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_edges();
    send_interval(XMin, XMax);
    send_interval(XMax, XMin);
    send_interval('0, '0);
    send_interval('0, 32'sd1);
    send_interval('1, '0);
    send_interval(2 * XOne, 3 * XOne);
    send_interval(-XOne, '0);
    send_interval(5 * XOne, 4 * XOne);
    send_interval(-8 * XOne, 8 * XOne);
    send_interval(32'sh5555_5555, 32'shAAAA_AAAA);
    send_interval(XMax, XMax - XWidth'(TolReset));
    send_interval('0, XWidth'(TolReset) + 32'sd1);
    drain_results(SettleCycles);
  endtask

  task automatic test_zero_tolerance();
    // top bit falls outside the register, leaving a tolerance of zero
    drive_reg(RegTol, 32'h8000_0000);
    send_interval('0, 32'sd1);
    send_interval(3 * XOne, 2 * XOne);
    send_interval(XMin, XMax);
    send_interval(5 * XOne, 5 * XOne);
    drain_results(SettleCycles);
  endtask

  task automatic test_coef_extremes();
    drive_reg(RegSpareLo, $urandom);
    drive_reg(RegSpareHi, $urandom);
    drive_reg(RegCubic,  coef_word(16'h8000));
    drive_reg(RegSquare, coef_word(16'h7FFF));
    drive_reg(RegLinear, coef_word(16'h8000));
    drive_reg(RegConst,  coef_word(16'h7FFF));
    drive_reg(RegTol,    32'h7FFF_FFFF);
    send_interval(XMin, XMax);
    send_interval('0, XMax);
    drain_results(SettleCycles);
    drive_reg(RegCubic,  coef_word(16'h7FFF));
    drive_reg(RegSquare, coef_word(16'h8000));
    drive_reg(RegLinear, coef_word(16'h7FFF));
    drive_reg(RegConst,  coef_word(16'h8000));
    drive_reg(RegTol,    32'd1);
    send_interval(XMin, XMax);
    send_interval(2 * XOne, 3 * XOne);
    drain_results(SettleCycles);
    // flat polynomial: the sign test never fires
    drive_reg(RegCubic,  '0);
    drive_reg(RegSquare, '0);
    drive_reg(RegLinear, '0);
    drive_reg(RegConst,  '0);
    send_interval(-8 * XOne, 8 * XOne);
    drain_results(SettleCycles);
  endtask

  task automatic test_random_intervals(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned count);
    logic signed [XWidth-1:0] lo_end;
    logic signed [XWidth-1:0] hi_end;
    program_random_config();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick_endpoints(lo_end, hi_end);
      send_interval(lo_end, hi_end);
    end
    drain_results(SettleCycles);
  endtask

  task automatic test_backpressure();
    logic signed [XWidth-1:0] lo_end;
    logic signed [XWidth-1:0] hi_end;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_off_ev;
    repeat (PressureItems) begin
      pick_endpoints(lo_end, hi_end);
      send_interval(lo_end, hi_end);
    end
    drain_results(SettleCycles);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    lower_end_i    = '0;
    upper_end_i    = '0;
    out_stall_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hold_active    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    mismatch_count = 0;
    intervals_sent = 0;
    roots_checked  = 0;
    limit_hits     = 0;
    zero_step_roots = 0;
    reg_writes     = 0;
    coefs.cubic    = CubicReset;
    coefs.square   = SquareReset;
    coefs.linear   = LinearReset;
    coefs.konst    = ConstReset;
    tol_q24        = TolReset;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_zero_tolerance();
    test_coef_extremes();
    test_random_intervals(0, 0, PhaseItems);
    test_random_intervals(69, 0, PhaseItems);
    test_random_intervals(0, 69, PhaseItems);
    test_random_intervals(12, 12, PhaseItems);
    test_backpressure();
    drain_results(EndSettle);

    $display("Checked %0d roots from %0d intervals across %0d register writes.",
             roots_checked, intervals_sent, reg_writes);
    $display("%0d stopped at the step limit, %0d took no step, %0d mismatches.",
             limit_hits, zero_step_roots, mismatch_count);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
